// ----- rtl/core/bss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

    localparam int MAX_ELEMS_DEF = 64;
    localparam int VALUE_W       = 8;

    // commands from the controller to the datapath
    typedef struct packed {
        logic in_write;    // request taken on the input side
        logic close;       // closing request, sample mode and restart ranks
        logic scan_start;  // clear scan pointer and best candidate
        logic scan_run;    // scan pass in progress
        logic out_load;    // load result register from the scan winner
        logic next_rank;   // result taken, winner becomes lower bound
        logic set_done;    // last result taken, empty the buffer
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_done;   // last buffered entry compared this cycle
        logic rank_last;   // current rank is the final one of the set
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/bss_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/bss_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bss_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          s_tlast,
    output      logic          s_tready,
    output      logic          m_tvalid,
    input  wire logic          m_tready,
    output      bss_pkg::cmd_t cmd,
    input  wire bss_pkg::sts_t sts
);

    import bss_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        case (state_reg)
            ST_LOAD: begin
                cmd.in_write = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    cmd.close      = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (sts.rank_last) begin
                        cmd.set_done = 1'b1;
                        state_next   = ST_LOAD;
                    end else begin
                        cmd.next_rank  = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next    = ST_LOAD;
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bss_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bss_datapath #(
    parameter int MAX_ELEMS = bss_pkg::MAX_ELEMS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_data,
    input  wire logic [bss_pkg::VALUE_W-1:0] in_value,
    output      logic [bss_pkg::VALUE_W-1:0] out_value,
    output      logic                        out_last,
    output      logic                        out_overflow,
    input  wire bss_pkg::cmd_t               cmd,
    output      bss_pkg::sts_t               sts
);

    import bss_pkg::*;

    localparam int IW = $clog2(MAX_ELEMS);
    localparam int CW = $clog2(MAX_ELEMS + 1);
    // sort word: zero flag, value, buffer index (index breaks ties)
    localparam int KW = 1 + VALUE_W + IW;

    logic          zero_is_max_reg;
    logic          mode_reg;
    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic [CW-1:0] rd_ptr_reg;
    logic          pipe_vld_reg;
    logic [IW-1:0] pipe_idx_reg;
    logic [KW-1:0] best_reg, best_next;
    logic          best_vld_reg;
    logic [KW-1:0] prev_reg;
    logic          have_prev_reg;
    logic [IW-1:0] rank_reg;

    logic [VALUE_W-1:0] rd_data;
    logic               wr_en;
    logic               issue;
    logic [CW-1:0]      count_m1;
    logic [KW-1:0]      cur_key;
    logic               take;

    assign wr_en    = cmd.in_write && (count_reg < CW'(MAX_ELEMS));
    assign issue    = cmd.scan_run && (rd_ptr_reg < count_reg);
    assign count_m1 = count_reg - CW'(1);

    bss_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ELEMS)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (in_value),
        .rd_addr (rd_ptr_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    // entry must lie above the last emitted one and below the current best
    assign cur_key = {mode_reg && (rd_data == '0), rd_data, pipe_idx_reg};
    assign take    = pipe_vld_reg && (!have_prev_reg || (cur_key > prev_reg))
                     && (!best_vld_reg || (cur_key < best_reg));
    assign best_next = take ? cur_key : best_reg;

    assign sts.scan_done = pipe_vld_reg && (CW'(pipe_idx_reg) == count_m1);
    assign sts.rank_last = (CW'(rank_reg) == count_m1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_is_max_reg <= 1'b0;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
            pipe_vld_reg    <= 1'b0;
            best_vld_reg    <= 1'b0;
            have_prev_reg   <= 1'b0;
            rd_ptr_reg      <= '0;
            rank_reg        <= '0;
        end else begin
            if (cfg_valid) begin
                zero_is_max_reg <= cfg_data;
            end
            if (cmd.in_write) begin
                if (wr_en) begin
                    count_reg <= count_reg + CW'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.set_done) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            pipe_vld_reg <= issue;
            if (cmd.scan_start) begin
                rd_ptr_reg   <= '0;
                best_vld_reg <= 1'b0;
            end else begin
                if (issue) begin
                    rd_ptr_reg <= rd_ptr_reg + CW'(1);
                end
                if (take) begin
                    best_vld_reg <= 1'b1;
                end
            end
            if (cmd.close) begin
                have_prev_reg <= 1'b0;
                rank_reg      <= '0;
            end else if (cmd.next_rank) begin
                have_prev_reg <= 1'b1;
                rank_reg      <= rank_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.close) begin
            mode_reg <= zero_is_max_reg;
        end
        pipe_idx_reg <= rd_ptr_reg[IW-1:0];
        best_reg     <= best_next;
        if (cmd.next_rank) begin
            prev_reg <= best_reg;
        end
        if (cmd.out_load) begin
            out_value    <= best_next[IW +: VALUE_W];
            out_last     <= sts.rank_last;
            out_overflow <= ovf_reg;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ELEMS))
        else $error("buffer fill count above capacity");

    a_winner_found: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (best_vld_reg || take))
        else $error("scan ended without a candidate");

    a_pipe_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_vld_reg |-> (CW'(pipe_idx_reg) < count_reg))
        else $error("scan read beyond the buffered set");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/byte_shell_sorter_zero_last.sv -----
// throughput: one input request per cycle while loading a set
// sorting: each result costs one full scan of the buffer on its single ram
//   read port, plus the output handshake
// reset: aresetn synchronous active low; clears fill count, overflow, mode
//   and handshake state; buffer contents are left as they are
`timescale 1ns / 1ps
`default_nettype none

module byte_shell_sorter_zero_last #(
    parameter int MAX_ELEMS = bss_pkg::MAX_ELEMS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input stream
    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] elem_value
    input  wire logic       s_tlast,   // elem_last
    // result stream
    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata,   // [7:0] sorted_value
    output      logic       m_tlast,   // sorted_last
    output      logic [0:0] m_tuser,   // [0] overflow
    // mode register write (zero_is_max)
    input  wire logic       cfg_valid,
    output      logic       cfg_ready,
    input  wire logic       cfg_data
);

    import bss_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // mode register is always writable
    assign cfg_ready = 1'b1;

    // controller: load, scan for next rank, present result
    bss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath: element buffer, scan compare, result register
    bss_datapath #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .in_value     (s_tdata),
        .out_value    (m_tdata),
        .out_last     (m_tlast),
        .out_overflow (m_tuser[0]),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

`default_nettype wire
